### hw/rtl/lzp_order4_decompressor_unit_defines.svh
// ----------------------------------------------------------------------------
// LZP decompressor assertion macros
// Shared property wrappers for the decompressor top level.
// ----------------------------------------------------------------------------
`ifndef LZP_ORDER4_DECOMPRESSOR_UNIT_DEFINES_SVH
`define LZP_ORDER4_DECOMPRESSOR_UNIT_DEFINES_SVH

// Same-cycle implication, clocked on clk, off during reset
`define LZPD_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, clocked on clk, off during reset
`define LZPD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hw/rtl/lzpd_pkg.sv
// ----------------------------------------------------------------------------
// LZP decompressor package
// Shared types and constants of the order-4 LZP decompressor.
// ----------------------------------------------------------------------------
`default_nettype none

package lzpd_pkg;

    // Bytes of context before the first flag byte
    localparam int unsigned CTX_ORDER = 4;

    // Empty position table entry
    localparam logic [31:0] EMPTY_POS = 32'hFFFF_FFFF;

    // Reset value of the output limit register
    localparam logic [31:0] LIMIT_RESET = 32'h0001_0000;

    // Register index of the output limit
    localparam logic REG_OUTPUT_LIMIT = 1'b0;

    // Result status codes
    localparam logic [1:0] STAT_OK     = 2'd0;
    localparam logic [1:0] STAT_EMPTY  = 2'd1;
    localparam logic [1:0] STAT_WINDOW = 2'd2;

    // One compressed input word
    typedef struct packed {
        logic [7:0] in_byte;
        logic       start_of_stream;
        logic       last_input;
    } item_t;

    // One result word
    typedef struct packed {
        logic [31:0] out_bytes;
        logic [2:0]  out_count;
        logic        last_of_run;
        logic [1:0]  status;
        logic        stream_done;
    } res_t;

    // Back-end sequencer states
    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_TOK,
        S_PUT,
        S_HDR,
        S_CRD,
        S_CWR,
        S_END,
        S_STAT,
        S_FIN
    } core_state_t;

endpackage

`default_nettype wire

### hw/rtl/lzpd_if.sv
// ----------------------------------------------------------------------------
// LZP decompressor channels
// Valid/ready channels for compressed input words and result words.
// ----------------------------------------------------------------------------
`default_nettype none

interface lzpd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       start_of_stream;
    logic       last_input;

    modport source (output valid, in_byte, start_of_stream, last_input, input ready);
    modport sink   (input valid, in_byte, start_of_stream, last_input, output ready);
endinterface

interface lzpd_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] out_bytes;
    logic [2:0]  out_count;
    logic        last_of_run;
    logic [1:0]  status;
    logic        stream_done;

    modport source (output valid, out_bytes, out_count, last_of_run, status, stream_done,
                    input ready);
    modport sink   (input valid, out_bytes, out_count, last_of_run, status, stream_done,
                    output ready);
endinterface

`default_nettype wire

### hw/rtl/lzpd_front.sv
// ----------------------------------------------------------------------------
// LZP decompressor front end
// Accepts compressed words into a two-entry queue for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module lzpd_front
    import lzpd_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    lzpd_in_if.sink    in_ch,
    output item_t      item,
    output logic       item_valid,
    input  wire logic  item_pop
);

    item_t      q_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       push;

    assign in_ch.ready = (cnt_reg != 2'd2);
    assign push        = in_ch.valid && in_ch.ready;
    assign item        = q_reg[rd_ptr_reg];
    assign item_valid  = (cnt_reg != 2'd0);

    // pointer and fill bookkeeping
    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = item_pop ? ~rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + 2'(push) - 2'(item_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // queue storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= '{in_byte:         in_ch.in_byte,
                                   start_of_stream: in_ch.start_of_stream,
                                   last_input:      in_ch.last_input};
        end
    end

endmodule

`default_nettype wire

### hw/rtl/lzpd_core.sv
// ----------------------------------------------------------------------------
// LZP decompressor back end
// Decodes header, flag, literal and match words, copies from history and
// packs output bytes into result words.
// ----------------------------------------------------------------------------
`default_nettype none

module lzpd_core
    import lzpd_pkg::*;
#(
    parameter int unsigned HASH_BITS     = 16,
    parameter int unsigned HISTORY_DEPTH = 65536
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire item_t       item,
    input  wire logic        item_valid,
    output logic             item_pop,
    input  wire logic [31:0] output_limit,
    output res_t             res,
    output logic             res_valid,
    input  wire logic        res_ready
);

    localparam int unsigned HA = $clog2(HISTORY_DEPTH);
    localparam int unsigned TBL_DEPTH = 1 << HASH_BITS;

    // ------------------------------------------------------------------ state
    core_state_t         state_reg, state_next;
    logic [HASH_BITS-1:0] clr_addr_reg, clr_addr_next;
    logic                cleared_reg, cleared_next;
    logic [31:0]         ctx_reg, ctx_next;
    logic [31:0]         bw_reg, bw_next;
    logic [HA-1:0]       wr_ptr_reg, wr_ptr_next;
    logic [7:0]          flag_reg, flag_next;
    logic [3:0]          tok_reg, tok_next;
    logic [2:0]          hdr_reg, hdr_next;
    logic                fin_reg, fin_next;
    item_t               cur_reg, cur_next;
    logic [HASH_BITS-1:0] hash_reg, hash_next;
    logic                is_match_reg, is_match_next;
    logic                is_hdr_reg, is_hdr_next;
    logic [1:0]          status_reg, status_next;
    logic                done_reg, done_next;
    logic [HA-1:0]       src_reg, src_next;
    logic [7:0]          cnt_reg, cnt_next;
    logic [31:0]         pack_word_reg, pack_word_next;
    logic [1:0]          pack_cnt_reg, pack_cnt_next;
    logic                pend_valid_reg, pend_valid_next;
    res_t                pend_reg, pend_next;
    logic                out_valid_reg, out_valid_next;
    res_t                out_reg, out_next;

    // memories
    logic [31:0]          tbl_mem [TBL_DEPTH];
    logic [31:0]          tbl_rd_reg;
    logic [7:0]           hist_mem [HISTORY_DEPTH];
    logic [7:0]           hist_rd_reg;

    // memory port controls
    logic                 tbl_we;
    logic [HASH_BITS-1:0] tbl_waddr;
    logic [31:0]          tbl_wdata;
    logic [HASH_BITS-1:0] tbl_raddr;
    logic                 hist_we;
    logic                 hist_re;

    // misc
    logic                 out_free, push_ok, stall;
    logic                 put_en;
    logic [7:0]           put_byte;
    logic                 push_en;
    res_t                 push_res;
    logic                 flush_en;
    logic [31:0]          pos;
    logic [31:0]          diff;
    logic [HA:0]          back_dist;
    logic [HA:0]          wr_ext;
    logic [HA:0]          src_calc;

    function automatic logic [HASH_BITS-1:0] ctx_hash(input logic [31:0] c);
        logic [31:0] x;
        x = (c >> 15) ^ c;
        return x[HASH_BITS-1:0];
    endfunction

    function automatic logic [HA-1:0] ptr_inc(input logic [HA-1:0] p);
        return (p == HA'(HISTORY_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign res       = out_reg;
    assign res_valid = out_valid_reg;
    assign out_free  = !out_valid_reg || res_ready;
    assign push_ok   = !pend_valid_reg || out_free;
    assign tbl_raddr = ctx_hash(ctx_reg);

    // match source checks
    assign pos       = tbl_rd_reg;
    assign diff      = bw_reg - pos;
    assign back_dist = diff[HA:0];
    assign wr_ext    = {1'b0, wr_ptr_reg};
    assign src_calc  = (wr_ext >= back_dist) ? (wr_ext - back_dist)
                                             : (wr_ext + (HA+1)'(HISTORY_DEPTH) - back_dist);

    // stall while a result cannot be placed
    always_comb
    begin
        stall = 1'b0;
        case (state_reg)
            S_PUT, S_CWR: stall = (pack_cnt_reg == 2'd3) && !push_ok;
            S_END:        stall = (pack_cnt_reg != 2'd0) && !push_ok;
            S_STAT:       stall = (status_reg != STAT_OK) && !push_ok;
            S_FIN:        stall = (pend_valid_reg || done_reg) && !out_free;
            default:      stall = 1'b0;
        endcase
    end

    // ------------------------------------------------------------ next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_CLEAR:
            begin
                if (clr_addr_reg == HASH_BITS'(TBL_DEPTH - 1))
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (item_valid)
                begin
                    if (item.start_of_stream && !cleared_reg)
                        state_next = S_CLEAR;
                    else if (!item.start_of_stream && fin_reg)
                        state_next = S_IDLE;
                    else if (hdr_reg < 3'(CTX_ORDER))
                        state_next = S_PUT;
                    else if (tok_reg >= 4'd8)
                        state_next = S_END;
                    else
                        state_next = S_TOK;
                end
            end
            S_TOK:
            begin
                if (!is_match_reg)
                    state_next = S_PUT;
                else if (cur_reg.in_byte == 8'd0 || pos == EMPTY_POS || pos >= bw_reg
                         || diff > 32'(HISTORY_DEPTH))
                    state_next = S_END;
                else
                    state_next = S_CRD;
            end
            S_PUT:
            begin
                if (!stall)
                    state_next = is_hdr_reg ? S_HDR : S_END;
            end
            S_HDR:   state_next = S_END;
            S_CRD:   state_next = (fin_reg || cnt_reg == 8'd0) ? S_END : S_CWR;
            S_CWR:
            begin
                if (!stall)
                    state_next = S_CRD;
            end
            S_END:
            begin
                if (!stall)
                    state_next = S_STAT;
            end
            S_STAT:
            begin
                if (!stall)
                    state_next = S_FIN;
            end
            S_FIN:
            begin
                if (!stall)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    // ------------------------------------------------------------- datapath
    always_comb
    begin
        clr_addr_next   = clr_addr_reg;
        cleared_next    = cleared_reg;
        ctx_next        = ctx_reg;
        bw_next         = bw_reg;
        wr_ptr_next     = wr_ptr_reg;
        flag_next       = flag_reg;
        tok_next        = tok_reg;
        hdr_next        = hdr_reg;
        fin_next        = fin_reg;
        cur_next        = cur_reg;
        hash_next       = hash_reg;
        is_match_next   = is_match_reg;
        is_hdr_next     = is_hdr_reg;
        status_next     = status_reg;
        done_next       = done_reg;
        src_next        = src_reg;
        cnt_next        = cnt_reg;
        pack_word_next  = pack_word_reg;
        pack_cnt_next   = pack_cnt_reg;
        item_pop        = 1'b0;
        tbl_we          = 1'b0;
        tbl_waddr       = hash_reg;
        tbl_wdata       = bw_reg;
        hist_re         = 1'b0;
        put_en          = 1'b0;
        put_byte        = cur_reg.in_byte;
        push_en         = 1'b0;
        push_res        = '{out_bytes: pack_word_reg, out_count: {1'b0, pack_cnt_reg},
                            last_of_run: 1'b0, status: STAT_OK, stream_done: done_reg};
        flush_en        = 1'b0;

        case (state_reg)
            // sweep the position table to empty
            S_CLEAR:
            begin
                tbl_we        = 1'b1;
                tbl_waddr     = clr_addr_reg;
                tbl_wdata     = EMPTY_POS;
                clr_addr_next = clr_addr_reg + 1'b1;
            end
            // take a word and classify it, or start a table sweep ahead of a start-of-stream word
            S_IDLE:
            begin
                if (item_valid)
                begin
                    if (item.start_of_stream && !cleared_reg)
                    begin
                        cleared_next  = 1'b1;
                        clr_addr_next = '0;
                        ctx_next      = '0;
                        bw_next       = '0;
                        wr_ptr_next   = '0;
                        flag_next     = '0;
                        tok_next      = 4'd8;
                        hdr_next      = '0;
                        fin_next      = 1'b0;
                    end
                    else
                    begin
                        item_pop       = 1'b1;
                        cleared_next   = 1'b0;
                        cur_next       = item;
                        pack_word_next = '0;
                        pack_cnt_next  = '0;
                        status_next    = STAT_OK;
                        if (item.start_of_stream || !fin_reg)
                        begin
                            if (hdr_reg < 3'(CTX_ORDER))
                            begin
                                hdr_next    = hdr_reg + 1'b1;
                                is_hdr_next = 1'b1;
                                done_next   = item.last_input
                                              || ({1'b0, bw_reg} + 33'd1
                                                  >= {1'b0, output_limit});
                            end
                            else if (tok_reg >= 4'd8)
                            begin
                                flag_next = item.in_byte;
                                tok_next  = '0;
                                done_next = item.last_input;
                            end
                            else
                            begin
                                hash_next     = tbl_raddr;
                                is_match_next = flag_reg[7];
                                flag_next     = {flag_reg[6:0], 1'b0};
                                tok_next      = tok_reg + 1'b1;
                            end
                        end
                    end
                end
            end
            // table entry read back: store position, check the match
            S_TOK:
            begin
                tbl_we      = 1'b1;
                is_hdr_next = 1'b0;
                done_next   = cur_reg.last_input;
                if (!is_match_reg)
                    done_next = cur_reg.last_input
                                || ({1'b0, bw_reg} + 33'd1 >= {1'b0, output_limit});
                else if (cur_reg.in_byte != 8'd0)
                begin
                    if (pos == EMPTY_POS)
                        status_next = STAT_EMPTY;
                    else if (pos >= bw_reg || diff > 32'(HISTORY_DEPTH))
                        status_next = STAT_WINDOW;
                    else
                    begin
                        src_next  = src_calc[HA-1:0];
                        cnt_next  = cur_reg.in_byte;
                        done_next = cur_reg.last_input
                                    || ({1'b0, bw_reg} + 33'(cur_reg.in_byte)
                                        >= {1'b0, output_limit});
                    end
                end
            end
            S_PUT:
            begin
                put_en = !stall;
            end
            // end of header: record its position
            S_HDR:
            begin
                tbl_waddr = tbl_raddr;
                tbl_we    = (hdr_reg == 3'(CTX_ORDER)) && !fin_reg;
            end
            // issue one history read
            S_CRD:
            begin
                if (!fin_reg && cnt_reg != 8'd0)
                begin
                    hist_re  = 1'b1;
                    src_next = ptr_inc(src_reg);
                    cnt_next = cnt_reg - 1'b1;
                end
            end
            S_CWR:
            begin
                put_en   = !stall;
                put_byte = hist_rd_reg;
            end
            // partial word left in the packer
            S_END:
            begin
                if (pack_cnt_reg != 2'd0 && !stall)
                begin
                    push_en       = 1'b1;
                    pack_cnt_next = '0;
                end
            end
            S_STAT:
            begin
                if (status_reg != STAT_OK && !stall)
                begin
                    push_en  = 1'b1;
                    push_res = '{out_bytes: '0, out_count: '0, last_of_run: 1'b0,
                                 status: status_reg, stream_done: done_reg};
                end
            end
            S_FIN:
            begin
                if (!stall)
                begin
                    flush_en = pend_valid_reg || done_reg;
                    fin_next = fin_reg || cur_reg.last_input;
                end
            end
            default:
            begin
                cleared_next = cleared_reg;
            end
        endcase

        // one output byte: history, context, counters, packer
        if (put_en)
        begin
            ctx_next    = {ctx_reg[23:0], put_byte};
            bw_next     = bw_reg + 1'b1;
            wr_ptr_next = ptr_inc(wr_ptr_reg);
            fin_next    = fin_reg || ({1'b0, bw_reg} + 33'd1 >= {1'b0, output_limit});
            pack_word_next = pack_word_reg | (32'(put_byte) << {pack_cnt_reg, 3'b000});
            pack_cnt_next  = pack_cnt_reg + 1'b1;
            if (pack_cnt_reg == 2'd3)
            begin
                push_en        = 1'b1;
                push_res       = '{out_bytes: pack_word_next, out_count: 3'd4,
                                   last_of_run: 1'b0, status: STAT_OK,
                                   stream_done: done_reg};
                pack_word_next = '0;
            end
        end
    end

    assign hist_we = put_en;

    // pending result and output register
    always_comb
    begin
        pend_next       = pend_reg;
        pend_valid_next = pend_valid_reg;
        out_next        = out_reg;
        out_valid_next  = out_valid_reg && !res_ready;
        if (push_en)
        begin
            if (pend_valid_reg)
            begin
                out_next       = pend_reg;
                out_valid_next = 1'b1;
            end
            pend_next       = push_res;
            pend_valid_next = 1'b1;
        end
        if (flush_en)
        begin
            if (pend_valid_reg)
            begin
                out_next             = pend_reg;
                out_next.last_of_run = 1'b1;
            end
            else
            begin
                out_next = '{out_bytes: '0, out_count: '0, last_of_run: 1'b1,
                             status: STAT_OK, stream_done: 1'b1};
            end
            out_valid_next  = 1'b1;
            pend_valid_next = 1'b0;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            clr_addr_reg   <= '0;
            cleared_reg    <= 1'b0;
            ctx_reg        <= '0;
            bw_reg         <= '0;
            wr_ptr_reg     <= '0;
            flag_reg       <= '0;
            tok_reg        <= 4'd8;
            hdr_reg        <= '0;
            fin_reg        <= 1'b0;
            status_reg     <= STAT_OK;
            done_reg       <= 1'b0;
            pack_cnt_reg   <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            clr_addr_reg   <= clr_addr_next;
            cleared_reg    <= cleared_next;
            ctx_reg        <= ctx_next;
            bw_reg         <= bw_next;
            wr_ptr_reg     <= wr_ptr_next;
            flag_reg       <= flag_next;
            tok_reg        <= tok_next;
            hdr_reg        <= hdr_next;
            fin_reg        <= fin_next;
            status_reg     <= status_next;
            done_reg       <= done_next;
            pack_cnt_reg   <= pack_cnt_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        cur_reg       <= cur_next;
        hash_reg      <= hash_next;
        is_match_reg  <= is_match_next;
        is_hdr_reg    <= is_hdr_next;
        src_reg       <= src_next;
        cnt_reg       <= cnt_next;
        pack_word_reg <= pack_word_next;
        pend_reg      <= pend_next;
        out_reg       <= out_next;
    end

    // position table: one write port, registered read
    always_ff @(posedge clk)
    begin
        if (tbl_we)
            tbl_mem[tbl_waddr] <= tbl_wdata;
        tbl_rd_reg <= tbl_mem[tbl_raddr];
    end

    // history: written per output byte, registered read
    always_ff @(posedge clk)
    begin
        if (hist_we)
            hist_mem[wr_ptr_reg] <= put_byte;
        if (hist_re)
            hist_rd_reg <= hist_mem[src_reg];
    end

endmodule

`default_nettype wire

### hw/rtl/lzp_order4_decompressor_unit.sv
// ----------------------------------------------------------------------------
// LZP order-4 decompressor
// in_ch carries one compressed byte per word with start/last marks; out_ch
// carries up to four output bytes per word (first in bits 7:0), a count, a
// status and end-of-run/end-of-stream marks. output_limit is set over APB.
// A two-entry input queue takes words while the back end works or a result
// waits. Each copied match byte is one history read then one history
// write. A result waits in the pending register, one packed word behind,
// until the next result or the end of its word moves it to the output
// register. After reset, and ahead of every start-of-stream word, the
// position table is swept empty with no word taken. A stalled out_ch
// holds the back end once its pending and output registers are full; the
// input queue fills and in_ch.ready drops.
// ----------------------------------------------------------------------------
`default_nettype none

`include "lzp_order4_decompressor_unit_defines.svh"

module lzp_order4_decompressor_unit
    import lzpd_pkg::*;
#(
    parameter int unsigned HASH_BITS     = 16,
    parameter int unsigned HISTORY_DEPTH = 65536
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    lzpd_in_if.sink          in_ch,
    lzpd_out_if.source       out_ch,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    logic [31:0] limit_reg, limit_next;
    item_t       item;
    logic        item_valid;
    logic        item_pop;
    res_t        res;
    logic        res_valid;

    // configuration register
    assign pready = 1'b1;

    always_comb
    begin
        limit_next = limit_reg;
        if (psel && penable && pwrite && paddr[2] == REG_OUTPUT_LIMIT)
            limit_next = pwdata;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            limit_reg <= LIMIT_RESET;
        else
            limit_reg <= limit_next;
    end

    assign prdata = (paddr[2] == REG_OUTPUT_LIMIT) ? limit_reg : '0;

    // front end: input queue
    lzpd_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_ch      (in_ch),
        .item       (item),
        .item_valid (item_valid),
        .item_pop   (item_pop)
    );

    // back end: decode, copy, pack
    lzpd_core #(
        .HASH_BITS     (HASH_BITS),
        .HISTORY_DEPTH (HISTORY_DEPTH)
    ) u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .item         (item),
        .item_valid   (item_valid),
        .item_pop     (item_pop),
        .output_limit (limit_reg),
        .res          (res),
        .res_valid    (res_valid),
        .res_ready    (out_ch.ready)
    );

    assign out_ch.valid       = res_valid;
    assign out_ch.out_bytes   = res.out_bytes;
    assign out_ch.out_count   = res.out_count;
    assign out_ch.last_of_run = res.last_of_run;
    assign out_ch.status      = res.status;
    assign out_ch.stream_done = res.stream_done;

    // a word without bytes reports an error or closes a finished stream
    `LZPD_ASSERT_NOW(a_empty_word, out_ch.valid && out_ch.out_count == 3'd0, out_ch.status != STAT_OK || (out_ch.stream_done && out_ch.last_of_run), "empty result word without cause")
    // byte words are never error words and hold at most four bytes
    `LZPD_ASSERT_NOW(a_byte_word, out_ch.valid && out_ch.out_count != 3'd0, out_ch.status == STAT_OK && out_ch.out_count <= 3'd4, "bad byte result word")
    // an APB write lands in the limit register
    `LZPD_ASSERT_NEXT(a_cfg_write, psel && penable && pwrite && !paddr[2], limit_reg == $past(pwdata), "output limit write lost")

endmodule

`default_nettype wire
